[rtl/core/line_rasterizer_bresenham_unit_defines.svh]
// Assertion macros for the line rasterizer checker.
`ifndef LINE_RASTERIZER_BRESENHAM_UNIT_DEFINES_SVH
`define LINE_RASTERIZER_BRESENHAM_UNIT_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define LRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrb checker: implication failed");

// Next-cycle implication, masked during reset.
`define LRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrb checker: next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define LRB_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lrb checker: reset check failed");

`endif

[rtl/core/lrb_pkg.sv]
// Shared types and codes for the line rasterizer.
`timescale 1ns / 1ps

package lrb_pkg;

   // tuser code on the request channel
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_NEXT = 1'b1;

   typedef enum logic [1:0] {
      SLOPE_SHALLOW_UP   = 2'd0,  // x major, y rises
      SLOPE_SHALLOW_DOWN = 2'd1,  // x major, y falls, step on E >= 0
      SLOPE_STEEP_UP     = 2'd2,  // y major and rises
      SLOPE_STEEP_DOWN   = 2'd3   // y major and falls
   } slope_case_type;

endpackage

[rtl/core/lrb_setup.sv]
// Endpoint ordering, slope case selection and initial error terms for a load.
`timescale 1ns / 1ps

module lrb_setup #(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]   x_start,
   input  logic [COORD_BITS-1:0]   y_start,
   input  logic [COORD_BITS-1:0]   x_end,
   input  logic [COORD_BITS-1:0]   y_end,
   output lrb_pkg::slope_case_type slope,
   output logic [COORD_BITS-1:0]   major_pos,
   output logic [COORD_BITS-1:0]   major_end,
   output logic [COORD_BITS-1:0]   minor_pos,
   output logic [COORD_BITS+3:0]   error_term,
   output logic [COORD_BITS+1:0]   error_add,
   output logic [COORD_BITS+1:0]   error_sub
);
   import lrb_pkg::*;

   localparam int EW = COORD_BITS + 4;

   logic [COORD_BITS-1:0] xa, ya, xb, yb;
   logic [COORD_BITS-1:0] dx, dy_abs, big, small_span;
   logic                  y_up, steep;

   always_comb begin
      // equal x keeps the given order
      if (x_start > x_end) begin
         xa = x_end;
         ya = y_end;
         xb = x_start;
         yb = y_start;
      end else begin
         xa = x_start;
         ya = y_start;
         xb = x_end;
         yb = y_end;
      end
      dx   = xb - xa;
      y_up = (yb >= ya);
      dy_abs = y_up ? (yb - ya) : (ya - yb);
      steep  = (dy_abs > dx);

      case ({steep, y_up})
         2'b01:   slope = SLOPE_SHALLOW_UP;
         2'b00:   slope = SLOPE_SHALLOW_DOWN;
         2'b11:   slope = SLOPE_STEEP_UP;
         default: slope = SLOPE_STEEP_DOWN;
      endcase

      big        = steep ? dy_abs : dx;
      small_span = steep ? dx : dy_abs;
      major_pos  = steep ? ya : xa;
      major_end  = steep ? yb : xb;
      minor_pos  = steep ? xa : ya;

      error_term = EW'(0) - EW'(big);
      error_add  = {1'b0, small_span, 1'b0};
      error_sub  = {1'b0, big, 1'b0};
   end

endmodule

[rtl/core/lrb_step.sv]
// One walk step: error update, minor step decision, pixel select, last flag.
`timescale 1ns / 1ps

module lrb_step #(
   parameter int COORD_BITS = 12
) (
   input  lrb_pkg::slope_case_type slope,
   input  logic [COORD_BITS-1:0]   major_pos,
   input  logic [COORD_BITS-1:0]   major_end,
   input  logic [COORD_BITS-1:0]   minor_pos,
   input  logic [COORD_BITS+3:0]   error_term,
   input  logic [COORD_BITS+1:0]   error_add,
   input  logic [COORD_BITS+1:0]   error_sub,
   output logic [COORD_BITS-1:0]   major_pos_next,
   output logic [COORD_BITS-1:0]   minor_pos_next,
   output logic [COORD_BITS+3:0]   error_term_next,
   output logic [COORD_BITS-1:0]   pixel_x,
   output logic [COORD_BITS-1:0]   pixel_y,
   output logic                    last
);
   import lrb_pkg::*;

   localparam int EW = COORD_BITS + 4;

   logic          err_neg, err_zero, minor_step;
   logic [EW-1:0] err_sub_sel;

   always_comb begin
      err_neg  = error_term[EW-1];
      err_zero = (error_term == '0);
      // shallow falling lines step on E >= 0, all others on E > 0
      if (slope == SLOPE_SHALLOW_DOWN) begin
         minor_step = !err_neg;
      end else begin
         minor_step = !err_neg && !err_zero;
      end

      if (!minor_step) begin
         minor_pos_next = minor_pos;
      end else if (slope == SLOPE_SHALLOW_DOWN) begin
         minor_pos_next = minor_pos - COORD_BITS'(1);
      end else begin
         minor_pos_next = minor_pos + COORD_BITS'(1);
      end

      err_sub_sel     = minor_step ? EW'(error_sub) : '0;
      error_term_next = error_term - err_sub_sel + EW'(error_add);

      if (slope == SLOPE_SHALLOW_UP || slope == SLOPE_SHALLOW_DOWN) begin
         pixel_x = major_pos;
         pixel_y = minor_pos_next;
      end else begin
         pixel_x = minor_pos_next;
         pixel_y = major_pos;
      end

      last = (major_pos == major_end);
      if (last) begin
         major_pos_next = major_pos;
      end else if (slope == SLOPE_STEEP_DOWN) begin
         major_pos_next = major_pos - COORD_BITS'(1);
      end else begin
         major_pos_next = major_pos + COORD_BITS'(1);
      end
   end

endmodule

[rtl/core/line_rasterizer_bresenham_unit.sv]
// Top level of the Bresenham line rasterizer.
//
// Request channel (req_*): tuser is the action, 0 = load, 1 = next pixel.
// A load item carries both endpoints in tdata and gives no result; the line
// is ordered so that x rises and one of four slope cases is chosen.
// Each next item gives exactly one result item on the rsp_* channel: the
// pixel in tdata, tlast on the line's final endpoint, tuser = 1 for a real
// pixel. A next item with no line active gives a result with tuser = 0 and
// all other fields zero. A load while a line is active drops that line.
// Timing: an accepted item sits in the input register, then the walk logic
// updates the line state and fills the result register, from which the
// result is offered. Throughput is one item per cycle while the result
// register is not stalled; the walk state loop (a subtract, an add and
// compares) is combinational between the line state registers, so next
// items may follow back to back.
// When rsp_tready is low the result register holds; loads still pass, and
// req_tready drops only once a next item is held in the input register too.
// Reset (synchronous, active high) clears both valid flags and idles the walk.
`timescale 1ns / 1ps

module line_rasterizer_bresenham_unit #(
   parameter int COORD_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // x_start, y_start, x_end, y_end from bit 0 up, zero pad to bytes
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   // action
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // pixel_x, pixel_y from bit 0 up, zero pad to bytes
   output logic [((2*COORD_BITS+7)/8)*8-1:0]      rsp_tdata,
   // last_pixel
   output logic                                   rsp_tlast,
   // pixel_valid
   output logic                                   rsp_tuser
);
   import lrb_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int EW    = COORD_BITS + 4;
   localparam int AW    = COORD_BITS + 2;
   localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

   // input register
   logic          in_valid_ff, in_valid_in;
   logic          in_action_ff;
   logic [CB-1:0] in_xs_ff, in_ys_ff, in_xe_ff, in_ye_ff;

   // line state
   slope_case_type slope_ff, slope_in;
   logic [CB-1:0]  major_pos_ff, major_pos_in;
   logic [CB-1:0]  major_end_ff, major_end_in;
   logic [CB-1:0]  minor_pos_ff, minor_pos_in;
   logic [EW-1:0]  error_term_ff, error_term_in;
   logic [AW-1:0]  error_add_ff, error_add_in;
   logic [AW-1:0]  error_sub_ff, error_sub_in;
   logic           active_ff, active_in;

   // result register
   logic          out_valid_ff, out_valid_in;
   logic [CB-1:0] out_x_ff, out_x_in;
   logic [CB-1:0] out_y_ff, out_y_in;
   logic          out_last_ff, out_last_in;
   logic          out_pv_ff, out_pv_in;

   logic req_fire, advance, is_load, out_free;

   slope_case_type ld_slope;
   logic [CB-1:0]  ld_major_pos, ld_major_end, ld_minor_pos;
   logic [EW-1:0]  ld_error_term;
   logic [AW-1:0]  ld_error_add, ld_error_sub;

   logic [CB-1:0] st_major_pos, st_minor_pos, st_pixel_x, st_pixel_y;
   logic [EW-1:0] st_error_term;
   logic          st_last;

   lrb_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .x_start    (in_xs_ff),
      .y_start    (in_ys_ff),
      .x_end      (in_xe_ff),
      .y_end      (in_ye_ff),
      .slope      (ld_slope),
      .major_pos  (ld_major_pos),
      .major_end  (ld_major_end),
      .minor_pos  (ld_minor_pos),
      .error_term (ld_error_term),
      .error_add  (ld_error_add),
      .error_sub  (ld_error_sub)
   );

   lrb_step #(.COORD_BITS(COORD_BITS)) u_step (
      .slope           (slope_ff),
      .major_pos       (major_pos_ff),
      .major_end       (major_end_ff),
      .minor_pos       (minor_pos_ff),
      .error_term      (error_term_ff),
      .error_add       (error_add_ff),
      .error_sub       (error_sub_ff),
      .major_pos_next  (st_major_pos),
      .minor_pos_next  (st_minor_pos),
      .error_term_next (st_error_term),
      .pixel_x         (st_pixel_x),
      .pixel_y         (st_pixel_y),
      .last            (st_last)
   );

   always_comb begin
      is_load  = (in_action_ff == ACTION_LOAD);
      out_free = !out_valid_ff || rsp_tready;
      // loads never touch the result register, so they never wait on it
      advance    = in_valid_ff && (is_load || out_free);
      req_tready = !in_valid_ff || advance;
      req_fire   = req_tvalid && req_tready;
      in_valid_in = req_fire || (in_valid_ff && !advance);
   end

   always_comb begin
      slope_in      = slope_ff;
      major_pos_in  = major_pos_ff;
      major_end_in  = major_end_ff;
      minor_pos_in  = minor_pos_ff;
      error_term_in = error_term_ff;
      error_add_in  = error_add_ff;
      error_sub_in  = error_sub_ff;
      active_in     = active_ff;

      out_valid_in = out_valid_ff && !rsp_tready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      out_pv_in    = out_pv_ff;

      if (advance && is_load) begin
         slope_in      = ld_slope;
         major_pos_in  = ld_major_pos;
         major_end_in  = ld_major_end;
         minor_pos_in  = ld_minor_pos;
         error_term_in = ld_error_term;
         error_add_in  = ld_error_add;
         error_sub_in  = ld_error_sub;
         active_in     = 1'b1;
      end else if (advance) begin
         out_valid_in = 1'b1;
         if (active_ff) begin
            major_pos_in  = st_major_pos;
            minor_pos_in  = st_minor_pos;
            error_term_in = st_error_term;
            active_in     = !st_last;
            out_x_in      = st_pixel_x;
            out_y_in      = st_pixel_y;
            out_last_in   = st_last;
            out_pv_in     = 1'b1;
         end else begin
            // next with no line: empty result
            out_x_in    = '0;
            out_y_in    = '0;
            out_last_in = 1'b0;
            out_pv_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         active_ff     <= 1'b0;
         slope_ff      <= SLOPE_SHALLOW_UP;
         major_pos_ff  <= '0;
         major_end_ff  <= '0;
         minor_pos_ff  <= '0;
         error_term_ff <= '0;
         error_add_ff  <= '0;
         error_sub_ff  <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         active_ff     <= active_in;
         slope_ff      <= slope_in;
         major_pos_ff  <= major_pos_in;
         major_end_ff  <= major_end_in;
         minor_pos_ff  <= minor_pos_in;
         error_term_ff <= error_term_in;
         error_add_ff  <= error_add_in;
         error_sub_ff  <= error_sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_tuser;
         in_xs_ff     <= req_tdata[CB-1:0];
         in_ys_ff     <= req_tdata[2*CB-1:CB];
         in_xe_ff     <= req_tdata[3*CB-1:2*CB];
         in_ye_ff     <= req_tdata[4*CB-1:3*CB];
      end
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
      out_pv_ff   <= out_pv_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = OUT_W'({out_y_ff, out_x_ff});
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_pv_ff;

endmodule

[rtl/core/lrb_checker.sv]
// Port-level checker for the line rasterizer, bound to the top level.
`timescale 1ns / 1ps
`include "line_rasterizer_bresenham_unit_defines.svh"

module lrb_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              rsp_tuser
);
   import lrb_pkg::*;

   logic next_fire;

   assign next_fire = req_tvalid && req_tready && (req_tuser == ACTION_NEXT);

   // a stalled result stays offered
   `LRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // the last-pixel flag only rides on a real pixel
   `LRB_ASSERT_IMPL(a_last_real, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)

   // an empty result carries zero coordinates
   `LRB_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

   // a fresh result follows an accepted next item, through the input and result registers
   `LRB_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(next_fire, 2))

   // reset leaves no result pending
   `LRB_ASSERT_ALWAYS_NEXT(a_reset_idle, clock, reset, !rsp_tvalid)

endmodule

bind line_rasterizer_bresenham_unit lrb_checker #(.COORD_BITS(COORD_BITS)) u_lrb_checker (.*);

[sim/lrb_pixel_checker.sv]
// Checker for the line rasterizer: predicts each pixel item and compares the results.
`timescale 1ns / 1ps

module lrb_pixel_checker
   import lrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,    // x_start, y_start, x_end, y_end
   input  logic        req_tuser,    // action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // pixel_x, pixel_y
   input  logic        rsp_tlast,    // last_pixel
   input  logic        rsp_tuser,    // pixel_valid
   output int          fail_count,
   output int          pixels_owed
);

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic        last;
      logic        valid;
   } pixel_type;

   pixel_type pixel_queue[$];

   // predicted walk state
   logic [11:0]        major_pos;
   logic [11:0]        major_end;
   logic [11:0]        minor_pos;
   logic signed [15:0] walk_err;
   logic [13:0]        err_add;
   logic [13:0]        err_sub;
   slope_case_type     slope;
   logic               line_active;
   int                 fails = 0;

   task automatic load_endpoints(input logic [47:0] pts);
      logic [11:0] xa, ya, xb, yb, t;
      int dx, dy, major_span, minor_span;
      xa = pts[11:0];
      ya = pts[23:12];
      xb = pts[35:24];
      yb = pts[47:36];
      // equal x keeps the given order
      if (xa > xb) begin
         t = xa; xa = xb; xb = t;
         t = ya; ya = yb; yb = t;
      end
      dx = int'(xb) - int'(xa);
      dy = int'(yb) - int'(ya);
      if (dy >= 0 && dy <= dx) begin
         slope = SLOPE_SHALLOW_UP;
         major_span = dx; minor_span = dy;
      end else if (dy < 0 && -dy <= dx) begin
         slope = SLOPE_SHALLOW_DOWN;
         major_span = dx; minor_span = -dy;
      end else if (dy > dx) begin
         slope = SLOPE_STEEP_UP;
         major_span = dy; minor_span = dx;
      end else begin
         slope = SLOPE_STEEP_DOWN;
         major_span = -dy; minor_span = dx;
      end
      if (slope == SLOPE_SHALLOW_UP || slope == SLOPE_SHALLOW_DOWN) begin
         major_pos = xa; major_end = xb; minor_pos = ya;
      end else begin
         major_pos = ya; major_end = yb; minor_pos = xa;
      end
      walk_err    = 16'(-major_span);
      err_add     = 14'(2 * minor_span);
      err_sub     = 14'(2 * major_span);
      line_active = 1'b1;
   endtask

   task automatic walk_pixel(output pixel_type px);
      logic step;
      px = '0;
      if (line_active) begin
         // shallow-down steps on E >= 0, so its tie goes the other way
         step = (slope == SLOPE_SHALLOW_DOWN) ? (walk_err >= 0) : (walk_err > 0);
         if (step) begin
            if (slope == SLOPE_SHALLOW_DOWN) minor_pos = minor_pos - 12'd1;
            else minor_pos = minor_pos + 12'd1;
            walk_err = walk_err - $signed({2'b00, err_sub});
         end
         if (slope == SLOPE_SHALLOW_UP || slope == SLOPE_SHALLOW_DOWN) begin
            px.x = major_pos; px.y = minor_pos;
         end else begin
            px.x = minor_pos; px.y = major_pos;
         end
         walk_err = walk_err + $signed({2'b00, err_add});
         px.last  = (major_pos == major_end);
         px.valid = 1'b1;
         if (px.last) line_active = 1'b0;
         else if (slope == SLOPE_STEEP_DOWN) major_pos = major_pos - 12'd1;
         else major_pos = major_pos + 12'd1;
      end
   endtask

   always @(posedge clock) begin
      pixel_type want, got;
      if (reset) begin
         major_pos   = '0;
         major_end   = '0;
         minor_pos   = '0;
         walk_err    = '0;
         err_add     = '0;
         err_sub     = '0;
         slope       = SLOPE_SHALLOW_UP;
         line_active = 1'b0;
         pixel_queue.delete();
      end else begin
         // a result is never caused by an item of the same cycle: pop first
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[11:0], rsp_tdata[23:12], rsp_tlast, rsp_tuser};
            if (pixel_queue.size() == 0) begin
               fails++;
               $display("%0t: unexpected pixel item x=%0d y=%0d last=%0b valid=%0b",
                        $time, got.x, got.y, got.last, got.valid);
            end else begin
               want = pixel_queue.pop_front();
               if (got !== want) begin
                  fails++;
                  $display("%0t: pixel mismatch exp x=%0d y=%0d last=%0b valid=%0b",
                           $time, want.x, want.y, want.last, want.valid);
                  $display("%0t:                got x=%0d y=%0d last=%0b valid=%0b",
                           $time, got.x, got.y, got.last, got.valid);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACTION_LOAD) begin
               load_endpoints(req_tdata);
            end else begin
               walk_pixel(want);
               pixel_queue.push_back(want);
            end
         end
      end
      fail_count  <= fails;
      pixels_owed <= pixel_queue.size();
   end

endmodule

[sim/tb.sv]
// Testbench top for the line rasterizer: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
   import lrb_pkg::*;

   localparam int COORD_BITS   = 12;
   localparam int COORD_MAX    = 4095;
   localparam int RANDOM_ITEMS = 550;
   localparam int IDLE_LIMIT   = 1000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   int fail_count;
   int pixels_owed;
   int items_sent  = 0;
   int idle_cycles = 0;
   bit quiet       = 1'b0;
   int stall_left  = 0;

   line_rasterizer_bresenham_unit #(.COORD_BITS(COORD_BITS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   lrb_pixel_checker pixel_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .pixels_owed (pixels_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, a few long ones, none while quiet
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   // uniform, with the edges of the range picked more often
   function automatic int pick_coord();
      case ($urandom_range(0, 15))
         0: return 0;
         1: return COORD_MAX;
         default: return $urandom_range(0, COORD_MAX);
      endcase
   endfunction

   task automatic send_item(input logic act, input logic [47:0] data);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic load_line(input int xa, input int ya, input int xb, input int yb);
      send_item(ACTION_LOAD, {12'(yb), 12'(xb), 12'(ya), 12'(xa)});
   endtask

   // tdata is don't-care on next items, so it carries noise
   task automatic next_pixels(input int n);
      repeat (n) send_item(ACTION_NEXT, 48'({$urandom, $urandom}));
   endtask

   // receiver stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 99) < 15)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      int start_count, xs, ys, xe, ye, span, walk, r;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      next_pixels(1);                          // next with no line
      load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      next_pixels(2);                          // single point, then idle again
      load_line(0, 0, 0, 2);                   // vertical, up
      next_pixels(3);
      load_line(2, 0, 0, 1);                   // swapped, shallow down, tie
      next_pixels(3);
      load_line(0, 0, 2, 1);                   // shallow up, tie
      next_pixels(3);
      load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 2); // equal x, down
      next_pixels(1);
      load_line(0, COORD_MAX, COORD_MAX, 0);   // replaces the active line
      next_pixels(2);
      load_line(COORD_MAX - 1, 0, COORD_MAX, 3); // steep up
      next_pixels(4);

      start_count = items_sent;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) quiet = ~quiet;
         r = $urandom_range(0, 99);
         if (r < 80) begin
            xs = pick_coord();
            ys = pick_coord();
            if ($urandom_range(0, 19) == 0) begin
               xe = pick_coord();
               ye = pick_coord();
            end else begin
               xe = clamp_coord(xs + $urandom_range(0, 32) - 16);
               ye = clamp_coord(ys + $urandom_range(0, 32) - 16);
            end
            span = ((xe > xs) ? xe - xs : xs - xe);
            if (((ye > ys) ? ye - ys : ys - ye) > span) span = (ye > ys) ? ye - ys : ys - ye;
            span++;
            load_line(xs, ys, xe, ye);
            // long lines and some short ones are cut off by the next load
            if (span > 40 || $urandom_range(0, 4) == 0)
               walk = $urandom_range(0, (span > 40) ? 40 : span - 1);
            else
               walk = span + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            next_pixels(walk);
         end else if (r < 90) begin
            load_line(pick_coord(), pick_coord(), pick_coord(), pick_coord());
         end else begin
            next_pixels(1);
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pixels_owed != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pixels_owed == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
